[src/pts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg: shared constants and helpers for the priority task scheduler
// Sizes of the priority maps, sleep counters and event codes.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int NUM_PRIO   = 32;
  localparam int MAX_TASKS  = 16;
  localparam int IDLE_PRIO  = 31;
  localparam int SLEEP_BITS = 16;

  localparam int SLOT_COUNT = 32;
  localparam int PRIO_W     = 5;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int TASK_W     = 6;
  localparam int NEST_W     = 8;
  localparam int TICK_W     = 32;
  localparam int IN_SLEEP_W = 16;
  localparam int MODE_W     = 4;

  localparam logic [MODE_W-1:0] MODE_CREATE    = 4'd0;
  localparam logic [MODE_W-1:0] MODE_READY_ADD = 4'd1;
  localparam logic [MODE_W-1:0] MODE_READY_REM = 4'd2;
  localparam logic [MODE_W-1:0] MODE_SET_SLEEP = 4'd3;
  localparam logic [MODE_W-1:0] MODE_TICK      = 4'd4;
  localparam logic [MODE_W-1:0] MODE_IRQ_ENTER = 4'd5;
  localparam logic [MODE_W-1:0] MODE_IRQ_LEAVE = 4'd6;
  localparam logic [MODE_W-1:0] MODE_SCHEDULE  = 4'd7;
  localparam logic [MODE_W-1:0] MODE_START     = 4'd8;

  localparam logic [SLOT_COUNT-1:0] PRIO_MASK =
    (NUM_PRIO >= SLOT_COUNT) ? {SLOT_COUNT{1'b1}} :
    SLOT_COUNT'((64'd1 << NUM_PRIO) - 64'd1);

  function automatic logic [PRIO_W-1:0] lowest_set(input logic [SLOT_COUNT-1:0] m);
    logic [PRIO_W-1:0] res;
    res = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (m[i]) begin
        res = PRIO_W'(i);
      end
    end
    return res;
  endfunction

endpackage

[src/priority_task_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_task_scheduler: bitmap priority scheduler with sleep ticks
// Keeps ready and active maps, per-priority sleep counters, the running
// priority, the interrupt nest level and the tick counter, one event a request.
// ----------------------------------------------------------------------------
//  Channel   Ports                                  Handshake
//  request   in_mode, in_prio, in_sleep_ticks       start && !busy
//  result    out_highest_prio .. out_error          out_valid, one cycle
//
//  A tick request passes through read, run and end states: the sleep
//  counters live in a 32-entry memory and one decrementer walks them, one
//  entry a cycle, on registered read data. Other requests use ST_EXEC only.
//  Synchronous active-low reset clears the maps, status registers and memory valid bits.
//  The receiver cannot stall; busy stays high from acceptance to the result.
// ----------------------------------------------------------------------------
module priority_task_scheduler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [pts_pkg::MODE_W-1:0]     in_mode,
  input  logic [pts_pkg::PRIO_W-1:0]     in_prio,
  input  logic [pts_pkg::IN_SLEEP_W-1:0] in_sleep_ticks,
  output logic                           out_valid,
  output logic [pts_pkg::PRIO_W-1:0]     out_highest_prio,
  output logic                           out_any_ready,
  output logic                           out_switch_request,
  output logic [pts_pkg::PRIO_W-1:0]     out_current_prio,
  output logic [pts_pkg::TICK_W-1:0]     out_tick_count,
  output logic [pts_pkg::NEST_W-1:0]     out_nest_level,
  output logic                           out_error
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK_RD,
    ST_TICK_RUN,
    ST_TICK_END
  } state_t;

  state_t state_r, state_nxt;

  logic [pts_pkg::MODE_W-1:0]     mode_r;
  logic [pts_pkg::PRIO_W-1:0]     prio_r;
  logic [pts_pkg::IN_SLEEP_W-1:0] sleep_r;

  logic [pts_pkg::SLOT_COUNT-1:0] ready_r, ready_nxt;
  logic [pts_pkg::SLOT_COUNT-1:0] active_r, active_nxt;
  logic [pts_pkg::PRIO_W-1:0]     highest_r, highest_nxt;
  logic [pts_pkg::PRIO_W-1:0]     running_r, running_nxt;
  logic [pts_pkg::NEST_W-1:0]     nest_r, nest_nxt;
  logic [pts_pkg::TICK_W-1:0]     ticks_r, ticks_nxt;
  logic [pts_pkg::TASK_W-1:0]     created_r, created_nxt;
  logic                           sw_r, sw_nxt;
  logic                           err_r, err_nxt;
  logic                           valid_r, valid_nxt;
  logic [pts_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic                           hit_r, hit_nxt;

  logic [pts_pkg::SLEEP_BITS-1:0] mem [pts_pkg::SLOT_COUNT];
  logic [pts_pkg::SLOT_COUNT-1:0] vld_r;
  logic [pts_pkg::SLEEP_BITS-1:0] rdata_r;
  logic                           rvld_r;
  logic [pts_pkg::IDX_W-1:0]      rd_addr;
  logic                           mem_we;
  logic [pts_pkg::IDX_W-1:0]      mem_waddr;
  logic [pts_pkg::SLEEP_BITS-1:0] mem_wdata;

  logic [pts_pkg::SLOT_COUNT-1:0] prio_bit;
  logic [pts_pkg::SLOT_COUNT-1:0] idx_bit;
  logic                           in_range;
  logic [pts_pkg::SLOT_COUNT-1:0] ready_masked;
  logic [pts_pkg::PRIO_W-1:0]     refreshed;
  logic [pts_pkg::SLEEP_BITS-1:0] cnt_cur;
  logic [pts_pkg::SLEEP_BITS-1:0] cnt_dec;
  logic                           cnt_elig;

  assign prio_bit     = pts_pkg::SLOT_COUNT'(1) << prio_r;
  assign idx_bit      = pts_pkg::SLOT_COUNT'(1) << idx_r;
  assign in_range     = ({1'b0, prio_r} < (pts_pkg::PRIO_W + 1)'(pts_pkg::NUM_PRIO));
  assign ready_masked = ready_r & pts_pkg::PRIO_MASK;
  assign refreshed    = (|ready_masked) ? pts_pkg::lowest_set(ready_masked) : highest_r;

  assign cnt_cur  = rvld_r ? rdata_r : '0;
  assign cnt_dec  = cnt_cur - pts_pkg::SLEEP_BITS'(1);
  assign cnt_elig = active_r[idx_r] && (idx_r != pts_pkg::IDX_W'(pts_pkg::IDLE_PRIO))
                    && (cnt_cur != '0);

  assign rd_addr = (state_r == ST_TICK_RD) ? '0 : idx_r + pts_pkg::IDX_W'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = cnt_dec;
    if (state_r == ST_EXEC && mode_r == pts_pkg::MODE_SET_SLEEP && in_range) begin
      mem_we    = 1'b1;
      mem_waddr = prio_r[pts_pkg::IDX_W-1:0];
      mem_wdata = pts_pkg::SLEEP_BITS'(sleep_r);
    end else if (state_r == ST_TICK_RUN && cnt_elig) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    ready_nxt   = ready_r;
    active_nxt  = active_r;
    highest_nxt = highest_r;
    running_nxt = running_r;
    nest_nxt    = nest_r;
    ticks_nxt   = ticks_r;
    created_nxt = created_r;
    sw_nxt      = 1'b0;
    err_nxt     = 1'b0;
    valid_nxt   = 1'b0;
    idx_nxt     = idx_r;
    hit_nxt     = hit_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_mode == pts_pkg::MODE_TICK) ? ST_TICK_RD : ST_EXEC;
        end
      end
      ST_EXEC: begin
        valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
        case (mode_r)
          pts_pkg::MODE_CREATE: begin
            if (in_range && created_r < pts_pkg::TASK_W'(pts_pkg::MAX_TASKS)) begin
              created_nxt = created_r + pts_pkg::TASK_W'(1);
              active_nxt  = active_r | prio_bit;
              ready_nxt   = ready_r | prio_bit;
            end else begin
              err_nxt = 1'b1;
            end
          end
          pts_pkg::MODE_READY_ADD: begin
            if (in_range) begin
              ready_nxt = ready_r | prio_bit;
            end
          end
          pts_pkg::MODE_READY_REM: begin
            if (in_range) begin
              ready_nxt = ready_r & ~prio_bit;
            end
          end
          pts_pkg::MODE_IRQ_ENTER: begin
            if (nest_r != '1) begin
              nest_nxt = nest_r + pts_pkg::NEST_W'(1);
            end
          end
          pts_pkg::MODE_IRQ_LEAVE: begin
            if (nest_r != '0) begin
              nest_nxt = nest_r - pts_pkg::NEST_W'(1);
              if (nest_r == pts_pkg::NEST_W'(1)) begin
                highest_nxt = refreshed;
                if (refreshed != running_r) begin
                  sw_nxt      = 1'b1;
                  running_nxt = refreshed;
                end
              end
            end
          end
          pts_pkg::MODE_SCHEDULE: begin
            if (nest_r == '0) begin
              highest_nxt = refreshed;
              if (refreshed != running_r) begin
                sw_nxt      = 1'b1;
                running_nxt = refreshed;
              end
            end
          end
          pts_pkg::MODE_START: begin
            highest_nxt = refreshed;
            running_nxt = refreshed;
          end
          default: begin
          end
        endcase
      end
      ST_TICK_RD: begin
        idx_nxt   = '0;
        hit_nxt   = 1'b0;
        state_nxt = ST_TICK_RUN;
      end
      ST_TICK_RUN: begin
        if (cnt_elig && cnt_dec == '0) begin
          ready_nxt = ready_r | idx_bit;
          hit_nxt   = 1'b1;
        end
        if (idx_r == pts_pkg::IDX_W'(pts_pkg::NUM_PRIO - 1)) begin
          state_nxt = ST_TICK_END;
        end else begin
          idx_nxt = idx_r + pts_pkg::IDX_W'(1);
        end
      end
      ST_TICK_END: begin
        ticks_nxt = ticks_r + pts_pkg::TICK_W'(1);
        if (hit_r) begin
          highest_nxt = refreshed;
        end
        valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ready_r   <= '0;
      active_r  <= '0;
      highest_r <= '0;
      running_r <= '0;
      nest_r    <= '0;
      ticks_r   <= '0;
      created_r <= '0;
      sw_r      <= 1'b0;
      err_r     <= 1'b0;
      valid_r   <= 1'b0;
      idx_r     <= '0;
      hit_r     <= 1'b0;
      vld_r     <= '0;
      rvld_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ready_r   <= ready_nxt;
      active_r  <= active_nxt;
      highest_r <= highest_nxt;
      running_r <= running_nxt;
      nest_r    <= nest_nxt;
      ticks_r   <= ticks_nxt;
      created_r <= created_nxt;
      sw_r      <= sw_nxt;
      err_r     <= err_nxt;
      valid_r   <= valid_nxt;
      idx_r     <= idx_nxt;
      hit_r     <= hit_nxt;
      rvld_r    <= vld_r[rd_addr];
      if (mem_we) begin
        vld_r[mem_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      mode_r  <= in_mode;
      prio_r  <= in_prio;
      sleep_r <= in_sleep_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = valid_r;
  assign out_highest_prio   = highest_r;
  assign out_any_ready      = |ready_masked;
  assign out_switch_request = sw_r;
  assign out_current_prio   = running_r;
  assign out_tick_count     = ticks_r;
  assign out_nest_level     = nest_r;
  assign out_error          = err_r;

endmodule

[src/pts_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_checker: port-level checks for the priority task scheduler
// Watches the request and result handshakes and the switch indication.
// ----------------------------------------------------------------------------
module pts_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic                       out_switch_request,
  input logic [pts_pkg::PRIO_W-1:0] out_highest_prio,
  input logic [pts_pkg::PRIO_W-1:0] out_current_prio
);

  // An accepted request keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted request");

  // A result is never shown while a request is still in progress.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Every request ends with exactly one result as busy drops.
  a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // A result strobe lasts a single cycle.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // A switch always moves the running priority to the highest ready one.
  a_switch_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_switch_request |-> out_current_prio == out_highest_prio)
    else $error("switch requested to a priority other than the highest ready");

endmodule

bind priority_task_scheduler pts_checker u_pts_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_switch_request (out_switch_request),
  .out_highest_prio   (out_highest_prio),
  .out_current_prio   (out_current_prio)
);

[dv/priority_task_scheduler_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_task_scheduler_test: self-checking bench for the task scheduler
// Sends directed and random scheduler events through the start/busy request
// port, predicts every result from a behavioral copy of the scheduler state
// and compares each strobed result, field by field, in request order.
// ----------------------------------------------------------------------------
module priority_task_scheduler_test;

  localparam int RUN_ITEMS   = 1850;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 40;
  localparam int NEST_BURST  = 258;

  typedef struct {
    logic [pts_pkg::MODE_W-1:0]     mode;
    logic [pts_pkg::PRIO_W-1:0]     prio;
    logic [pts_pkg::IN_SLEEP_W-1:0] count;
  } sched_req_t;

  typedef struct {
    logic [pts_pkg::PRIO_W-1:0] highest;
    logic                       any;
    logic                       sw;
    logic [pts_pkg::PRIO_W-1:0] current;
    logic [pts_pkg::TICK_W-1:0] ticks;
    logic [pts_pkg::NEST_W-1:0] nest;
    logic                       err;
  } sched_status_t;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic [pts_pkg::MODE_W-1:0]     in_mode;
  logic [pts_pkg::PRIO_W-1:0]     in_prio;
  logic [pts_pkg::IN_SLEEP_W-1:0] in_sleep_ticks;
  logic                           out_valid;
  logic [pts_pkg::PRIO_W-1:0]     out_highest_prio;
  logic                           out_any_ready;
  logic                           out_switch_request;
  logic [pts_pkg::PRIO_W-1:0]     out_current_prio;
  logic [pts_pkg::TICK_W-1:0]     out_tick_count;
  logic [pts_pkg::NEST_W-1:0]     out_nest_level;
  logic                           out_error;

  sched_req_t    pending_q[$];
  sched_status_t status_q[$];
  int            made_prio[$];
  int            total_requests;
  int            accepted;
  int            mismatches;
  int            cycles;
  logic          took;

  logic [pts_pkg::SLOT_COUNT-1:0] ready_bits;
  logic [pts_pkg::SLOT_COUNT-1:0] active_bits;
  logic [pts_pkg::SLEEP_BITS-1:0] sleep_left [pts_pkg::SLOT_COUNT];
  logic [pts_pkg::PRIO_W-1:0]     top_ready;
  logic [pts_pkg::PRIO_W-1:0]     run_prio;
  logic [pts_pkg::NEST_W-1:0]     nest;
  logic [pts_pkg::TICK_W-1:0]     tick_total;
  logic [pts_pkg::TASK_W-1:0]     created;

  priority_task_scheduler dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_prio            (in_prio),
    .in_sleep_ticks     (in_sleep_ticks),
    .out_valid          (out_valid),
    .out_highest_prio   (out_highest_prio),
    .out_any_ready      (out_any_ready),
    .out_switch_request (out_switch_request),
    .out_current_prio   (out_current_prio),
    .out_tick_count     (out_tick_count),
    .out_nest_level     (out_nest_level),
    .out_error          (out_error)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void refresh_top();
    for (int i = pts_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (ready_bits[i] && pts_pkg::PRIO_MASK[i]) begin
        top_ready = pts_pkg::PRIO_W'(i);
      end
    end
  endfunction

  function automatic logic try_switch();
    logic sw;
    sw = 1'b0;
    if (nest == '0) begin
      refresh_top();
      if (top_ready != run_prio) begin
        sw = 1'b1;
        run_prio = top_ready;
      end
    end
    return sw;
  endfunction

  function automatic sched_status_t apply_event(sched_req_t r);
    sched_status_t s;
    logic          sw;
    logic          err;
    logic          in_range;
    sw = 1'b0;
    err = 1'b0;
    in_range = int'(r.prio) < pts_pkg::NUM_PRIO;
    case (r.mode)
      pts_pkg::MODE_CREATE: begin
        if (in_range && created < pts_pkg::MAX_TASKS) begin
          created = created + 1'b1;
          active_bits[r.prio] = 1'b1;
          ready_bits[r.prio] = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      pts_pkg::MODE_READY_ADD: begin
        if (in_range) ready_bits[r.prio] = 1'b1;
      end
      pts_pkg::MODE_READY_REM: begin
        if (in_range) ready_bits[r.prio] = 1'b0;
      end
      pts_pkg::MODE_SET_SLEEP: begin
        if (in_range) sleep_left[r.prio] = pts_pkg::SLEEP_BITS'(r.count);
      end
      pts_pkg::MODE_TICK: begin
        tick_total = tick_total + 1'b1;
        for (int i = 0; i < pts_pkg::NUM_PRIO; i++) begin
          if (i != pts_pkg::IDLE_PRIO && active_bits[i] && sleep_left[i] != '0) begin
            sleep_left[i] = sleep_left[i] - 1'b1;
            if (sleep_left[i] == '0) begin
              ready_bits[i] = 1'b1;
              refresh_top();
            end
          end
        end
      end
      pts_pkg::MODE_IRQ_ENTER: begin
        if (nest != '1) nest = nest + 1'b1;
      end
      pts_pkg::MODE_IRQ_LEAVE: begin
        if (nest != '0) begin
          nest = nest - 1'b1;
          if (nest == '0) sw = try_switch();
        end
      end
      pts_pkg::MODE_SCHEDULE: begin
        sw = try_switch();
      end
      pts_pkg::MODE_START: begin
        refresh_top();
        run_prio = top_ready;
      end
      default: begin
      end
    endcase
    s.highest = top_ready;
    s.any     = |(ready_bits & pts_pkg::PRIO_MASK);
    s.sw      = sw;
    s.current = run_prio;
    s.ticks   = tick_total;
    s.nest    = nest;
    s.err     = err;
    return s;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("MISMATCH request %0d %s: got %0h, expected %0h", accepted, field, got, want);
  endtask

  task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(field, got, want);
  endtask

  function automatic void add_req(logic [pts_pkg::MODE_W-1:0] mode, int prio, int count);
    sched_req_t r;
    r.mode  = mode;
    r.prio  = pts_pkg::PRIO_W'(prio);
    r.count = pts_pkg::IN_SLEEP_W'(count);
    if (mode == pts_pkg::MODE_CREATE) made_prio.push_back(prio);
    pending_q.push_back(r);
  endfunction

  function automatic int pick_task();
    if (made_prio.size() == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 31);
    return made_prio[$urandom_range(0, made_prio.size() - 1)];
  endfunction

  function automatic void build_directed();
    for (int m = int'(pts_pkg::MODE_START) + 1; m < (1 << pts_pkg::MODE_W); m++) begin
      add_req(pts_pkg::MODE_W'(m), 31 - m, 16'hffff);
    end
    add_req(pts_pkg::MODE_START, 0, 0);
    add_req(pts_pkg::MODE_SCHEDULE, 0, 0);
    add_req(pts_pkg::MODE_IRQ_LEAVE, 0, 0);
    add_req(pts_pkg::MODE_CREATE, pts_pkg::IDLE_PRIO, 0);
    add_req(pts_pkg::MODE_CREATE, 0, 0);
    add_req(pts_pkg::MODE_CREATE, 17, 0);
    add_req(pts_pkg::MODE_CREATE, 14, 0);
    add_req(pts_pkg::MODE_SET_SLEEP, pts_pkg::IDLE_PRIO, 1);
    add_req(pts_pkg::MODE_SET_SLEEP, 17, 16'hffff);
    add_req(pts_pkg::MODE_SET_SLEEP, 14, 2);
    add_req(pts_pkg::MODE_READY_REM, 14, 0);
    add_req(pts_pkg::MODE_READY_REM, 0, 0);
    add_req(pts_pkg::MODE_SCHEDULE, 0, 0);
    add_req(pts_pkg::MODE_TICK, 0, 0);
    add_req(pts_pkg::MODE_TICK, 0, 0);
    add_req(pts_pkg::MODE_IRQ_ENTER, 0, 0);
    add_req(pts_pkg::MODE_SCHEDULE, 0, 0);
    add_req(pts_pkg::MODE_IRQ_LEAVE, 0, 0);
    add_req(pts_pkg::MODE_READY_ADD, 0, 16'hffff);
    add_req(pts_pkg::MODE_START, 31, 0);
  endfunction

  function automatic void build_random_part();
    int   p;
    int   n;
    logic burst_done;
    burst_done = 1'b0;
    while (pending_q.size() < RUN_ITEMS) begin
      if (!burst_done && pending_q.size() > 1000) begin
        burst_done = 1'b1;
        for (int i = 0; i < NEST_BURST; i++) begin
          add_req(pts_pkg::MODE_IRQ_ENTER, $urandom_range(0, 31), 0);
        end
        add_req(pts_pkg::MODE_SCHEDULE, 0, 0);
        for (int i = 0; i < NEST_BURST; i++) begin
          add_req(pts_pkg::MODE_IRQ_LEAVE, $urandom_range(0, 31), 0);
        end
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          p = pick_task();
          case ($urandom_range(0, 7))
            0: n = 16'hffff;
            1: n = 0;
            2: n = $urandom_range(0, 65535);
            default: n = $urandom_range(1, 5);
          endcase
          add_req(pts_pkg::MODE_SET_SLEEP, p, n);
          add_req(pts_pkg::MODE_READY_REM, p, $urandom_range(0, 65535));
          add_req(pts_pkg::MODE_SCHEDULE, 0, 0);
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) begin
            add_req(pts_pkg::MODE_TICK, $urandom_range(0, 31), $urandom_range(0, 65535));
            if ($urandom_range(0, 1)) add_req(pts_pkg::MODE_SCHEDULE, 0, 0);
          end
        end
        3: begin
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) add_req(pts_pkg::MODE_IRQ_ENTER, 0, 0);
          add_req(pts_pkg::MODE_READY_ADD, pick_task(), 0);
          add_req(pts_pkg::MODE_SCHEDULE, 0, 0);
          if ($urandom_range(0, 1)) add_req(pts_pkg::MODE_TICK, 0, 0);
          n = n + $urandom_range(0, 1);
          for (int i = 0; i < n; i++) add_req(pts_pkg::MODE_IRQ_LEAVE, 0, 0);
        end
        4: begin
          add_req(pts_pkg::MODE_CREATE, $urandom_range(0, 31), $urandom_range(0, 65535));
        end
        5: begin
          p = pick_task();
          add_req($urandom_range(0, 1) ? pts_pkg::MODE_READY_ADD : pts_pkg::MODE_READY_REM,
                  p, 0);
          add_req(pts_pkg::MODE_SCHEDULE, 0, 0);
        end
        6: begin
          add_req(pts_pkg::MODE_READY_REM, pick_task(), 0);
          add_req(pts_pkg::MODE_START, $urandom_range(0, 31), 0);
        end
        default: begin
          add_req(pts_pkg::MODE_W'($urandom_range(0, 15)), $urandom_range(0, 31),
                  $urandom_range(0, 65535));
        end
      endcase
    end
  endfunction

  always @(negedge clk) begin
    sched_req_t r;
    logic       idle_ok;
    idle_ok = !(accepted >= 700 && accepted < 1100);
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (pending_q.size() > 0 && !(idle_ok && $urandom_range(0, 99) < 16)) begin
        r = pending_q.pop_front();
        start          <= 1'b1;
        in_mode        <= r.mode;
        in_prio        <= r.prio;
        in_sleep_ticks <= r.count;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    sched_status_t want;
    sched_req_t    r;
    if (rst_n) begin
      if (out_valid) begin
        if (status_q.size() == 0) begin
          report_mismatch("unexpected result", 32'd1, 32'd0);
        end else begin
          want = status_q.pop_front();
          check_field("highest_prio", 32'(out_highest_prio), 32'(want.highest));
          check_field("any_ready", 32'(out_any_ready), 32'(want.any));
          check_field("switch_request", 32'(out_switch_request), 32'(want.sw));
          check_field("current_prio", 32'(out_current_prio), 32'(want.current));
          check_field("tick_count", out_tick_count, want.ticks);
          check_field("nest_level", 32'(out_nest_level), 32'(want.nest));
          check_field("error", 32'(out_error), 32'(want.err));
        end
      end
      if (start && !busy) begin
        r.mode  = in_mode;
        r.prio  = in_prio;
        r.count = in_sleep_ticks;
        status_q.push_back(apply_event(r));
        accepted++;
      end
    end
    took <= rst_n && start && !busy;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    ready_bits     = '0;
    active_bits    = '0;
    top_ready      = '0;
    run_prio       = '0;
    nest           = '0;
    tick_total     = '0;
    created        = '0;
    for (int i = 0; i < pts_pkg::SLOT_COUNT; i++) sleep_left[i] = '0;
    build_directed();
    build_random_part();
    total_requests = pending_q.size();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (accepted < total_requests || status_q.size() > 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
src/pts_pkg.sv
src/priority_task_scheduler.sv
src/pts_checker.sv
dv/priority_task_scheduler_test.sv
